// ----- design/euler_zxz_vector_rotate_top_macros.svh -----
// Assertion macros for the Euler ZXZ vector rotator
`ifndef EULER_ZXZ_VECTOR_ROTATE_TOP_MACROS_SVH
`define EULER_ZXZ_VECTOR_ROTATE_TOP_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define EZR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// assert that a condition holds at every edge out of reset
`define EZR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ----- design/ezr_pkg.sv -----
// Package of constants and helpers for the Euler ZXZ vector rotator
package ezr_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int QW = 31;
	localparam logic [30:0] Q_ONE = 31'h4000_0000;
	localparam logic [30:0] K1  = 31'd1686629713;
	localparam logic [30:0] K3  = 31'd693598668;
	localparam logic [30:0] K5  = 31'd85569305;
	localparam logic [30:0] K7  = 31'd5026995;
	localparam logic [30:0] K9  = 31'd172272;
	localparam logic [30:0] K11 = 31'd3864;
	localparam int NUM_CORE_STAGES = 14;
endpackage

// ----- design/ezr_sincos.sv -----
// Pipelined sine and cosine of one binary angle, signed Q30
module ezr_sincos import ezr_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ANGLE_WIDTH-1:0]   angle,
	output logic signed [31:0]       sin_q,
	output logic signed [31:0]       cos_q
);
	// stage registers: quadrant, x, x^2, Horner terms for sin and cos
	logic [1:0]  quad_s [0:7];
	logic [30:0] xs_s [0:7];
	logic [30:0] xc_s [0:7];
	logic [30:0] x2s_s [1:6];
	logic [30:0] x2c_s [1:6];
	logic [30:0] ts_s [1:6];
	logic [30:0] tc_s [1:6];
	logic [30:0] xin;
	logic [61:0] ps [1:7];
	logic [61:0] pc [1:7];
	logic [30:0] coef [2:6];

	assign coef[2] = K9;
	assign coef[3] = K7;
	assign coef[4] = K5;
	assign coef[5] = K3;
	assign coef[6] = K1;

	// map the fraction of a quarter turn to Q30
	always_comb begin
		logic [61:0] wide;
		wide = 62'(angle[ANGLE_WIDTH-3:0]) << (32 - ANGLE_WIDTH);
		xin = wide[30:0];
	end

	// stage 0: quadrant and both quarter-wave arguments
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[0] <= angle[ANGLE_WIDTH-1 -: 2];
			xs_s[0] <= xin;
			xc_s[0] <= Q_ONE - xin;
		end
	end

	// stage 1: x^2
	assign ps[1] = 62'(xs_s[0]) * 62'(xs_s[0]);
	assign pc[1] = 62'(xc_s[0]) * 62'(xc_s[0]);
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[1] <= quad_s[0];
			xs_s[1] <= xs_s[0];
			xc_s[1] <= xc_s[0];
			x2s_s[1] <= ps[1][60:30];
			x2c_s[1] <= pc[1][60:30];
			ts_s[1] <= K11;
			tc_s[1] <= K11;
		end
	end

	// stages 2..6: one Horner step each
	genvar g;
	generate
		for (g = 2; g <= 6; g++) begin : g_horner
			assign ps[g] = 62'(x2s_s[g-1]) * 62'(ts_s[g-1]);
			assign pc[g] = 62'(x2c_s[g-1]) * 62'(tc_s[g-1]);
			always_ff @(posedge clk) begin
				if (en) begin
					quad_s[g] <= quad_s[g-1];
					xs_s[g] <= xs_s[g-1];
					xc_s[g] <= xc_s[g-1];
					x2s_s[g] <= x2s_s[g-1];
					x2c_s[g] <= x2c_s[g-1];
					ts_s[g] <= coef[g] - ps[g][60:30];
					tc_s[g] <= coef[g] - pc[g][60:30];
				end
			end
		end
	endgenerate

	// stage 7: final multiply by x and clamp
	assign ps[7] = 62'(xs_s[6]) * 62'(ts_s[6]);
	assign pc[7] = 62'(xc_s[6]) * 62'(tc_s[6]);
	always_ff @(posedge clk) begin
		logic [31:0] sv, cv;
		sv = ps[7][61:30];
		cv = pc[7][61:30];
		if (en) begin
			quad_s[7] <= quad_s[6];
			xs_s[7] <= (sv > {1'b0, Q_ONE}) ? Q_ONE : sv[30:0];
			xc_s[7] <= (cv > {1'b0, Q_ONE}) ? Q_ONE : cv[30:0];
		end
	end

	// apply quadrant symmetry
	always_comb begin
		logic signed [31:0] sq, cq;
		sq = signed'({1'b0, xs_s[7]});
		cq = signed'({1'b0, xc_s[7]});
		unique case (quad_s[7])
			2'd0: begin sin_q = sq;  cos_q = cq;  end
			2'd1: begin sin_q = cq;  cos_q = -sq; end
			2'd2: begin sin_q = -sq; cos_q = -cq; end
			default: begin sin_q = -cq; cos_q = sq; end
		endcase
	end
endmodule

// ----- design/euler_zxz_vector_rotate_top.sv -----
// Euler ZXZ rotation of a Q16.16 point, 14-stage pipeline.
// Throughput: one request per cycle; a stall at the output freezes all
// stages together, set by the shared pipeline enable.
// Reset: arst_n clears all valid bits asynchronously; data is not reset.
`include "euler_zxz_vector_rotate_top_macros.svh"
module euler_zxz_vector_rotate_top import ezr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [ANGLE_WIDTH-1:0] outer_z_angle,
	input  logic signed [ANGLE_WIDTH-1:0] x_tilt_angle,
	input  logic signed [ANGLE_WIDTH-1:0] inner_z_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z
);
	localparam int NS = NUM_CORE_STAGES;
	localparam int PW = COORD_WIDTH + 33;
	localparam int AW = COORD_WIDTH + 35;
	localparam logic signed [AW-29:0] SAT_MAX =
		(AW-28)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [AW-29:0] SAT_MIN = -SAT_MAX - 1;

	logic en;
	logic [NS-1:0] vld_q;

	// advance the whole pipe unless the result is held
	assign en = !(vld_q[NS-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// trig units: 8 stages
	logic signed [31:0] sT, cT, sH, cH, sS, cS;
	ezr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_t (.clk, .en, .angle(outer_z_angle),
		.sin_q(sT), .cos_q(cT));
	ezr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_h (.clk, .en, .angle(x_tilt_angle),
		.sin_q(sH), .cos_q(cH));
	ezr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_s (.clk, .en, .angle(inner_z_angle),
		.sin_q(sS), .cos_q(cS));

	// delay point alongside trig and matrix build (10 stages)
	logic signed [COORD_WIDTH-1:0] pd_q [0:9][0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			pd_q[0][0] <= point_x;
			pd_q[0][1] <= point_y;
			pd_q[0][2] <= point_z;
			for (int i = 1; i <= 9; i++) pd_q[i] <= pd_q[i-1];
		end
	end

	// Q30 product rounded to nearest, ties away from zero
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [31:0] am, bm;
		logic [63:0] p;
		logic [31:0] r;
		am = a[31] ? 32'(-a) : 32'(a);
		bm = b[31] ? 32'(-b) : 32'(b);
		p = (64'(am) * 64'(bm)) + 64'(32'h2000_0000);
		r = p[61:30];
		return (a[31] ^ b[31]) ? signed'(-r) : signed'(r);
	endfunction

	// stage 9: first-level products
	logic signed [31:0] tc_s9, ts_s9, cTcS_s9, cTsS_s9, sTcS_s9, sTsS_s9;
	logic signed [31:0] sTsH_s9, cTsH_s9, sHsS_s9, sHcS_s9, cH_s9, sS_s9, cS_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			ts_s9 <= qmul(sT, cH);
			tc_s9 <= qmul(cT, cH);
			cTcS_s9 <= qmul(cT, cS);
			cTsS_s9 <= qmul(cT, sS);
			sTcS_s9 <= qmul(sT, cS);
			sTsS_s9 <= qmul(sT, sS);
			sTsH_s9 <= qmul(sT, sH);
			cTsH_s9 <= qmul(cT, sH);
			sHsS_s9 <= qmul(sH, sS);
			sHcS_s9 <= qmul(sH, cS);
			cH_s9 <= cH;
			sS_s9 <= sS;
			cS_s9 <= cS;
		end
	end

	// stage 10: matrix elements
	logic signed [33:0] m_s10 [0:8];
	always_ff @(posedge clk) begin
		if (en) begin
			m_s10[0] <= 34'(cTcS_s9) - 34'(qmul(ts_s9, sS_s9));
			m_s10[1] <= -34'(cTsS_s9) - 34'(qmul(ts_s9, cS_s9));
			m_s10[2] <= 34'(sTsH_s9);
			m_s10[3] <= 34'(sTcS_s9) + 34'(qmul(tc_s9, sS_s9));
			m_s10[4] <= -34'(sTsS_s9) + 34'(qmul(tc_s9, cS_s9));
			m_s10[5] <= -34'(cTsH_s9);
			m_s10[6] <= 34'(sHsS_s9);
			m_s10[7] <= 34'(sHcS_s9);
			m_s10[8] <= 34'(cH_s9);
		end
	end

	// stage 11: element times coordinate, split in halves
	logic signed [PW-1:0] plo_s11 [0:8];
	logic signed [PW-1:0] phi_s11 [0:8];
	localparam int HL = COORD_WIDTH / 2;
	always_ff @(posedge clk) begin
		logic signed [COORD_WIDTH-1:0] c;
		logic [HL:0] lo;
		logic signed [COORD_WIDTH-HL-1:0] hi;
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				c = pd_q[9][i % 3];
				lo = {1'b0, c[HL-1:0]};
				hi = c[COORD_WIDTH-1:HL];
				plo_s11[i] <= PW'(m_s10[i] * signed'(lo));
				phi_s11[i] <= PW'(m_s10[i] * hi);
			end
		end
	end

	// stage 12: recombine products
	logic signed [AW-1:0] p_s12 [0:8];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				p_s12[i] <= AW'(plo_s11[i]) + (AW'(phi_s11[i]) <<< HL);
		end
	end

	// stage 13: row sums with rounding bias
	logic signed [AW+1:0] acc_s13 [0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				acc_s13[r] <= (AW+2)'(p_s12[3*r]) + (AW+2)'(p_s12[3*r+1])
					+ (AW+2)'(p_s12[3*r+2]) + (AW+2)'(32'h2000_0000);
		end
	end

	// stage 14: shift and saturate
	logic signed [COORD_WIDTH-1:0] res_s14 [0:2];
	always_ff @(posedge clk) begin
		logic signed [AW-29:0] sh;
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sh = acc_s13[r][AW+1:30];
				if (sh > SAT_MAX)
					res_s14[r] <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
				else if (sh < SAT_MIN)
					res_s14[r] <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
				else
					res_s14[r] <= sh[COORD_WIDTH-1:0];
			end
		end
	end

	assign rotated_x = res_s14[0];
	assign rotated_y = res_s14[1];
	assign rotated_z = res_s14[2];

	// a held result stays put (only rotated_x is checked); in_stall mirrors a held output; valid leaves the last stages
	`EZR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(rotated_x), "result changed under stall")
	`EZR_ASSERT_ALWAYS(a_stall, clk, arst_n, in_stall == (out_valid && out_stall),
		"input stall not tied to output stall")
	`EZR_ASSERT_NEXT(a_adv, clk, arst_n, !in_stall && vld_q[NS-2],
		out_valid, "valid lost in pipe")
endmodule

// ----- sim/euler_zxz_vector_rotate_checker.sv -----
// Checker for the Euler ZXZ rotator: watches both channels, predicts and compares results
`timescale 1ns / 1ps
module euler_zxz_vector_rotate_checker import ezr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [15:0] outer_z_angle,
	input  logic signed [15:0] x_tilt_angle,
	input  logic signed [15:0] inner_z_angle,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] rotated_x,
	input  logic signed [31:0] rotated_y,
	input  logic signed [31:0] rotated_z,
	output int                 fail_count,
	output int                 pending,
	output logic               idle_cycle
);
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	point_t rotated_q[$];

	// quarter-wave sine of a Q30 fraction, truncating Horner evaluation
	function automatic longint unsigned quarter_wave(input longint unsigned x);
		longint unsigned x2, t;
		x2 = (x * x) >> 30;
		t = 64'(K11);
		t = 64'(K9) - ((x2 * t) >> 30);
		t = 64'(K7) - ((x2 * t) >> 30);
		t = 64'(K5) - ((x2 * t) >> 30);
		t = 64'(K3) - ((x2 * t) >> 30);
		t = 64'(K1) - ((x2 * t) >> 30);
		t = (x * t) >> 30;
		return (t > ONE_Q30) ? ONE_Q30 : t;
	endfunction

	// signed sine and cosine of a binary angle by quadrant symmetry
	function automatic void angle_trig(input logic [15:0] a, output longint s,
			output longint c);
		longint unsigned x;
		longint sq, cq;
		x = 64'(a[13:0]) << 16;
		sq = longint'(quarter_wave(x));
		cq = longint'(quarter_wave(ONE_Q30 - x));
		case (a[15:14])
			2'd0: begin s = sq; c = cq; end
			2'd1: begin s = cq; c = -sq; end
			2'd2: begin s = -sq; c = -cq; end
			default: begin s = -cq; c = sq; end
		endcase
	endfunction

	// Q30 product, round to nearest with ties away from zero
	function automatic longint mul_q30(input longint a, input longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		p = 128'(a) * 128'(b);
		m = p[127] ? -p : p;
		m = (m + (128'd1 << 29)) >> 30;
		return p[127] ? -longint'(m) : longint'(m);
	endfunction

	// sum of three element*coordinate products, round half up, saturate
	function automatic logic signed [31:0] row_dot(input longint m0, m1, m2,
			input logic signed [31:0] x, y, z);
		logic signed [127:0] acc;
		acc = 128'(m0) * 128'(x) + 128'(m1) * 128'(y) + 128'(m2) * 128'(z);
		acc = (acc + (128'sd1 <<< 29)) >>> 30;
		if (acc > 128'sd2147483647)
			return 32'sh7fff_ffff;
		if (acc < -128'sd2147483648)
			return 32'sh8000_0000;
		return acc[31:0];
	endfunction

	function automatic point_t rotate_zxz(input point_t p, input logic [15:0] th,
			input logic [15:0] ph, input logic [15:0] ps);
		longint st, ct, sh, ch, ss, cs;
		longint m[9];
		point_t r;
		angle_trig(th, st, ct);
		angle_trig(ph, sh, ch);
		angle_trig(ps, ss, cs);
		m[0] = mul_q30(ct, cs) - mul_q30(mul_q30(st, ch), ss);
		m[1] = -mul_q30(ct, ss) - mul_q30(mul_q30(st, ch), cs);
		m[2] = mul_q30(st, sh);
		m[3] = mul_q30(st, cs) + mul_q30(mul_q30(ct, ch), ss);
		m[4] = -mul_q30(st, ss) + mul_q30(mul_q30(ct, ch), cs);
		m[5] = -mul_q30(ct, sh);
		m[6] = mul_q30(sh, ss);
		m[7] = mul_q30(sh, cs);
		m[8] = ch;
		r.x = row_dot(m[0], m[1], m[2], p.x, p.y, p.z);
		r.y = row_dot(m[3], m[4], m[5], p.x, p.y, p.z);
		r.z = row_dot(m[6], m[7], m[8], p.x, p.y, p.z);
		return r;
	endfunction

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		point_t want, got, pred;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			idle_cycle <= 1'b0;
		end else begin
			idle_cycle <= !((in_valid && !in_stall) || (out_valid && !out_stall));
			if (in_valid && !in_stall) begin
				pred = rotate_zxz('{point_x, point_y, point_z},
					outer_z_angle, x_tilt_angle, inner_z_angle);
				rotated_q = {rotated_q, pred};
			end
			if (out_valid && !out_stall) begin
				got = '{rotated_x, rotated_y, rotated_z};
				if (rotated_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
					fail_count <= fail_count + 1;
				end else begin
					want = rotated_q.pop_front();
					if (want !== got) begin
						if (fail_count < 10)
							$display("result differs: expected %0d %0d %0d, got %0d %0d %0d",
								want.x, want.y, want.z, got.x, got.y, got.z);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= rotated_q.size();
		end
	end
endmodule

// ----- sim/tb_euler_zxz_vector_rotate_top.sv -----
// Testbench top for the Euler ZXZ rotator: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_euler_zxz_vector_rotate_top;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [15:0] outer_z_angle, x_tilt_angle, inner_z_angle;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] rotated_x, rotated_y, rotated_z;
	int fail_count;
	int pending;
	logic idle_cycle;
	logic hold_off;
	int quiet_cycles;

	euler_zxz_vector_rotate_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.outer_z_angle(outer_z_angle), .x_tilt_angle(x_tilt_angle),
		.inner_z_angle(inner_z_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z)
	);

	euler_zxz_vector_rotate_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.outer_z_angle(outer_z_angle), .x_tilt_angle(x_tilt_angle),
		.inner_z_angle(inner_z_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.fail_count(fail_count), .pending(pending), .idle_cycle(idle_cycle)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// random coordinate with bias toward extremes and small values
	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2, 3: return 32'($signed(17'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(0, 3)) << 14;
			1: return (16'($urandom_range(0, 3)) << 14) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one request and hold it until accepted
	task automatic send_point(input logic signed [31:0] x, y, z,
			input logic [15:0] th, ph, ps);
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		outer_z_angle <= th;
		x_tilt_angle <= ph;
		inner_z_angle <= ps;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drop_valid(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver stall pattern, with one long hold-off
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		while (1) begin
			@(posedge clk);
			if (hold_off)
				out_stall <= 1'b1;
			else
				case ($urandom_range(0, 3))
					0: out_stall <= ($urandom_range(0, 1) == 0);
					1: out_stall <= ($urandom_range(0, 7) == 0);
					default: out_stall <= 1'b0;
				endcase
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if (arst_n && idle_cycle) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("euler_zxz_vector_rotate_top: mismatch");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	initial begin
		logic [15:0] corners[4];
		int burst;
		corners = '{16'h0000, 16'h4000, 16'h8000, 16'hc000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		hold_off = 1'b0;
		point_x = '0; point_y = '0; point_z = '0;
		outer_z_angle = '0; x_tilt_angle = '0; inner_z_angle = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of coordinates and angle quadrant corners
		send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'h0000, 16'h0000, 16'h0000);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'h2000, 16'h2000, 16'h2000);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'h7fff, 16'h8000, 16'hffff);
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 16'h4000, 16'hc000, 16'h1234);
		send_point(32'shffff_ffff, 32'sh0000_0001, 32'sh7fff_ffff, 16'hffff, 16'h0001, 16'h8000);
		for (int i = 0; i < 4; i++)
			send_point(32'sh0010_0000, 32'shfff0_0000, 32'sh0008_0000,
				corners[i], corners[(i + 1) % 4], corners[(i + 2) % 4]);
		send_point(32'sh7fff_ffff, 32'sh0000_0000, 32'sh0000_0000, 16'h1fff, 16'h0000, 16'h0000);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 16'hdead, 16'hbeef, 16'h5555);
		send_point(32'shaaaa_aaaa, 32'sh5555_5555, 32'shffff_0000, 16'haaaa, 16'h5555, 16'h3fff);
		drop_valid(1);

		// long output hold-off while requests keep coming, fills the pipeline
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_point(pick_coord(), pick_coord(), pick_coord(),
					pick_angle(), pick_angle(), pick_angle());
		join
		drop_valid(1);

		// pause until every expected result has come
		while (pending != 0)
			@(posedge clk);

		// random bursts with random gaps
		for (int n = 0; n < RANDOM_REQUESTS; n += burst) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++)
				send_point(pick_coord(), pick_coord(), pick_coord(),
					pick_angle(), pick_angle(), pick_angle());
			drop_valid(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("euler_zxz_vector_rotate_top: match");
		else
			$display("euler_zxz_vector_rotate_top: mismatch");
		$finish;
	end
endmodule
